// ===== src/apu_frame_sequencer_unit_assert.svh =====
// Assertion macros for the frame sequencer unit
`ifndef APU_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define APU_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define AFS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame sequencer assertion failed");

// next-cycle implication
`define AFS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame sequencer assertion failed");

`endif

// ===== src/afs_pkg.sv =====
// Types, constants and helper functions of the frame sequencer unit
`default_nettype none

package afs_pkg;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned IDX_W    = 4;
   localparam int unsigned CH_W     = 2;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned PERIOD_W = 11;
   localparam int unsigned TARGET_W = PERIOD_W + 2;

   localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_REG    = 3'd1;
   localparam logic [OP_W-1:0] OP_FRAME_CTRL   = 3'd2;
   localparam logic [OP_W-1:0] OP_LOAD_LENGTH  = 3'd3;
   localparam logic [OP_W-1:0] OP_ENV_RELOAD   = 3'd4;
   localparam logic [OP_W-1:0] OP_SWEEP_RELOAD = 3'd5;

   localparam logic [CH_W-1:0] CH_PULSE0 = 2'd0;
   localparam logic [CH_W-1:0] CH_PULSE1 = 2'd1;
   localparam logic [CH_W-1:0] CH_TRI    = 2'd2;
   localparam logic [CH_W-1:0] CH_NOISE  = 2'd3;

   // register offsets within a channel
   localparam logic [1:0] REG_CTRL  = 2'd0;
   localparam logic [1:0] REG_SWEEP = 2'd1;
   localparam logic [1:0] REG_LO    = 2'd2;
   localparam logic [1:0] REG_HI    = 2'd3;

   localparam logic [IDX_W-1:0] TRI_REG = {CH_TRI, REG_CTRL};

   localparam int unsigned LOOP_HALT_BIT = 5;
   localparam int unsigned TRI_HALT_BIT  = 7;
   localparam int unsigned SWEEP_EN_BIT  = 7;
   localparam int unsigned NEGATE_BIT    = 3;
   localparam int unsigned RELOAD_REQ    = 7;
   localparam logic [3:0]  DECAY_FULL    = 4'hF;

   localparam int unsigned FC_INHIBIT = 0;
   localparam int unsigned FC_FIVE    = 1;

   localparam logic [2:0] FOUR_LAST = 3'd3;
   localparam logic [2:0] FIVE_IDLE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  reg_index;
      logic [CH_W-1:0]   channel;
      logic [DATA_W-1:0] data;
   } req_item_type;

   typedef struct packed {
      logic                frame_irq;
      logic [3:0]          length_active;
      logic [3:0]          pulse0_volume;
      logic [3:0]          pulse1_volume;
      logic [3:0]          noise_volume;
      logic                linear_active;
      logic [PERIOD_W-1:0] pulse0_period;
      logic [PERIOD_W-1:0] pulse1_period;
      logic [1:0]          sweep_mute;
   } rsp_item_type;

   // channel served by each envelope
   function automatic logic [CH_W-1:0] env_channel(input logic [1:0] e);
      return (e == 2'd2) ? CH_NOISE : e;
   endfunction

   // two's complement target, bit TARGET_W-1 set when negative
   function automatic logic [TARGET_W-1:0] sweep_target(input logic [PERIOD_W-1:0] period,
                                                       input logic [DATA_W-1:0]   ctl,
                                                       input logic               ones_comp);
      logic [PERIOD_W-1:0] chg;
      chg = period >> ctl[2:0];
      if (ctl[NEGATE_BIT]) begin
         return {2'b00, period} - {2'b00, chg} - {{(TARGET_W-1){1'b0}}, ones_comp};
      end
      return {2'b00, period} + {2'b00, chg};
   endfunction

endpackage

`default_nettype wire

// ===== src/afs_req_if.sv =====
// Request channel interface of the frame sequencer unit
`default_nettype none

interface afs_req_if;
   logic                        valid;
   logic                        ready;
   logic [afs_pkg::OP_W-1:0]    op;
   logic [afs_pkg::IDX_W-1:0]   reg_index;
   logic [afs_pkg::CH_W-1:0]    channel;
   logic [afs_pkg::DATA_W-1:0]  data;

   modport source (output valid, output op, output reg_index, output channel, output data,
                   input ready);
   modport sink   (input valid, input op, input reg_index, input channel, input data,
                   output ready);
endinterface

`default_nettype wire

// ===== src/afs_rsp_if.sv =====
// Response channel interface of the frame sequencer unit
`default_nettype none

interface afs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          frame_irq;
   logic [3:0]                    length_active;
   logic [3:0]                    pulse0_volume;
   logic [3:0]                    pulse1_volume;
   logic [3:0]                    noise_volume;
   logic                          linear_active;
   logic [afs_pkg::PERIOD_W-1:0]  pulse0_period;
   logic [afs_pkg::PERIOD_W-1:0]  pulse1_period;
   logic [1:0]                    sweep_mute;

   modport source (output valid, output frame_irq, output length_active,
                   output pulse0_volume, output pulse1_volume, output noise_volume,
                   output linear_active, output pulse0_period, output pulse1_period,
                   output sweep_mute, input ready);
   modport sink   (input valid, input frame_irq, input length_active,
                   input pulse0_volume, input pulse1_volume, input noise_volume,
                   input linear_active, input pulse0_period, input pulse1_period,
                   input sweep_mute, output ready);
endinterface

`default_nettype wire

// ===== src/afs_in_stage.sv =====
// Input register stage of the frame sequencer unit
`default_nettype none

module afs_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire afs_pkg::req_item_type in_item,
   input  wire logic                  advance,
   output logic                       hold_valid,
   output afs_pkg::req_item_type      hold_item
);

   logic                  valid_ff, valid_in;
   afs_pkg::req_item_type item_ff, item_in;

   always_comb begin
      in_ready = !valid_ff || advance;
      valid_in = in_ready ? in_valid : valid_ff;
      item_in  = (in_valid && in_ready) ? in_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

`default_nettype wire

// ===== src/afs_core.sv =====
// Sequencer state and single-pass update for one item
`default_nettype none
`include "apu_frame_sequencer_unit_assert.svh"

module afs_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire afs_pkg::req_item_type item,
   output afs_pkg::rsp_item_type      result
);

   logic [15:0][7:0] regs_ff, regs_in;
   logic [1:0]       fc_ff, fc_in;
   logic [2:0]       step_ff, step_in;
   logic [3:0][7:0]  len_ff, len_in;
   logic [2:0][7:0]  env_ff, env_in;
   logic [6:0]       lin_ff, lin_in;
   logic [1:0][7:0]  div_ff, div_in;
   logic [3:0]       reload_ff, reload_in;

   logic       tick, do_len, do_env, seq_irq;
   logic [2:0] step_next;
   logic [1:0][afs_pkg::TARGET_W-1:0] tgt_now, tgt_next;

   // frame step decode
   always_comb begin
      do_len    = 1'b0;
      do_env    = 1'b0;
      seq_irq   = 1'b0;
      step_next = step_ff + 3'd1;
      if (fc_ff[afs_pkg::FC_FIVE]) begin
         if (step_ff >= afs_pkg::FIVE_IDLE) begin
            step_next = 3'd0;
         end else begin
            do_env = 1'b1;
            do_len = !step_ff[0];
         end
      end else begin
         do_env = 1'b1;
         do_len = step_ff[0];
         if (step_ff >= afs_pkg::FOUR_LAST) begin
            seq_irq   = !fc_ff[afs_pkg::FC_INHIBIT];
            step_next = 3'd0;
         end
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         tgt_now[p[0]] = afs_pkg::sweep_target(
            {regs_ff[{p[1:0], afs_pkg::REG_HI}][2:0], regs_ff[{p[1:0], afs_pkg::REG_LO}]},
            regs_ff[{p[1:0], afs_pkg::REG_SWEEP}], p == 0);
      end
   end

   assign tick = fire && (item.op == afs_pkg::OP_TICK);

   always_comb begin
      logic [7:0]      m;
      logic [7:0]      ctl;
      logic [1:0]      c;
      logic            halt;
      m         = '0;
      ctl       = '0;
      c         = '0;
      halt      = 1'b0;
      regs_in   = regs_ff;
      fc_in     = fc_ff;
      step_in   = step_ff;
      len_in    = len_ff;
      env_in    = env_ff;
      lin_in    = lin_ff;
      div_in    = div_ff;
      reload_in = reload_ff;
      if (fire) begin
         unique case (item.op)
            afs_pkg::OP_TICK: begin
               step_in = step_next;
               if (do_len) begin
                  for (int ch = 0; ch < 4; ch++) begin
                     m    = regs_ff[{ch[1:0], afs_pkg::REG_CTRL}];
                     halt = (ch == 2) ? m[afs_pkg::TRI_HALT_BIT] : m[afs_pkg::LOOP_HALT_BIT];
                     if (!halt && len_ff[ch[1:0]] != 8'd0) begin
                        len_in[ch[1:0]] = len_ff[ch[1:0]] - 8'd1;
                     end
                  end
                  for (int p = 0; p < 2; p++) begin
                     ctl = regs_ff[{p[1:0], afs_pkg::REG_SWEEP}];
                     if (ctl[afs_pkg::SWEEP_EN_BIT] && ctl[2:0] != 3'd0
                         && div_ff[p[0]][2:0] == 3'd0 && tgt_now[p[0]][12:11] == 2'b00) begin
                        regs_in[{p[1:0], afs_pkg::REG_LO}]      = tgt_now[p[0]][7:0];
                        regs_in[{p[1:0], afs_pkg::REG_HI}][2:0] = tgt_now[p[0]][10:8];
                     end
                     if (div_ff[p[0]][afs_pkg::RELOAD_REQ]
                         || (div_ff[p[0]][2:0] == 3'd0 && ctl[afs_pkg::SWEEP_EN_BIT])) begin
                        div_in[p[0]] = {5'd0, ctl[6:4]};
                     end else if (div_ff[p[0]] != 8'd0) begin
                        div_in[p[0]] = div_ff[p[0]] - 8'd1;
                     end
                  end
               end
               if (do_env) begin
                  for (int e = 0; e < 3; e++) begin
                     c = afs_pkg::env_channel(e[1:0]);
                     m = regs_ff[{c, afs_pkg::REG_CTRL}];
                     if (reload_ff[c]) begin
                        env_in[e[1:0]] = {afs_pkg::DECAY_FULL, m[3:0]};
                        reload_in[c]   = 1'b0;
                     end else if (env_ff[e[1:0]][3:0] == 4'd0) begin
                        if (env_ff[e[1:0]][7:4] == 4'd0) begin
                           env_in[e[1:0]] = {m[afs_pkg::LOOP_HALT_BIT] ? afs_pkg::DECAY_FULL
                                                                        : 4'd0,
                                             m[3:0]};
                        end else begin
                           env_in[e[1:0]] = {env_ff[e[1:0]][7:4] - 4'd1, m[3:0]};
                        end
                     end else begin
                        env_in[e[1:0]] = env_ff[e[1:0]] - 8'd1;
                     end
                  end
                  if (reload_ff[afs_pkg::CH_TRI]) begin
                     lin_in = regs_ff[afs_pkg::TRI_REG][6:0];
                  end else if (lin_ff != 7'd0) begin
                     lin_in = lin_ff - 7'd1;
                  end
                  if (!regs_ff[afs_pkg::TRI_REG][afs_pkg::TRI_HALT_BIT]) begin
                     reload_in[afs_pkg::CH_TRI] = 1'b0;
                  end
               end
            end
            afs_pkg::OP_WRITE_REG:   regs_in[item.reg_index] = item.data;
            afs_pkg::OP_FRAME_CTRL:  fc_in = item.data[7:6];
            afs_pkg::OP_LOAD_LENGTH: len_in[item.channel] = item.data;
            afs_pkg::OP_ENV_RELOAD:  reload_in[item.channel] = 1'b1;
            afs_pkg::OP_SWEEP_RELOAD: begin
               if (item.channel == afs_pkg::CH_PULSE0 || item.channel == afs_pkg::CH_PULSE1) begin
                  div_in[item.channel[0]][afs_pkg::RELOAD_REQ] = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         tgt_next[p[0]] = afs_pkg::sweep_target(
            {regs_in[{p[1:0], afs_pkg::REG_HI}][2:0], regs_in[{p[1:0], afs_pkg::REG_LO}]},
            regs_in[{p[1:0], afs_pkg::REG_SWEEP}], p == 0);
      end
   end

   always_comb begin
      result.frame_irq = tick && seq_irq;
      for (int ch = 0; ch < 4; ch++) begin
         result.length_active[ch[1:0]] = (len_in[ch[1:0]] != 8'd0);
      end
      result.pulse0_volume = env_in[0][7:4];
      result.pulse1_volume = env_in[1][7:4];
      result.noise_volume  = env_in[2][7:4];
      result.linear_active = (lin_in != 7'd0);
      result.pulse0_period = {regs_in[{afs_pkg::CH_PULSE0, afs_pkg::REG_HI}][2:0],
                              regs_in[{afs_pkg::CH_PULSE0, afs_pkg::REG_LO}]};
      result.pulse1_period = {regs_in[{afs_pkg::CH_PULSE1, afs_pkg::REG_HI}][2:0],
                              regs_in[{afs_pkg::CH_PULSE1, afs_pkg::REG_LO}]};
      for (int p = 0; p < 2; p++) begin
         result.sweep_mute[p[0]] = !tgt_next[p[0]][12] && tgt_next[p[0]][11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff   <= '0;
         fc_ff     <= '0;
         step_ff   <= '0;
         len_ff    <= '0;
         env_ff    <= '0;
         lin_ff    <= '0;
         div_ff    <= '0;
         reload_ff <= '0;
      end else begin
         regs_ff   <= regs_in;
         fc_ff     <= fc_in;
         step_ff   <= step_in;
         len_ff    <= len_in;
         env_ff    <= env_in;
         lin_ff    <= lin_in;
         div_ff    <= div_in;
         reload_ff <= reload_in;
      end
   end

   `AFS_ASSERT_IMP(a_step_range, clock, reset, 1'b1, step_ff <= afs_pkg::FIVE_IDLE)
   `AFS_ASSERT_IMP(a_irq_on_tick, clock, reset, result.frame_irq, tick && !fc_ff[afs_pkg::FC_INHIBIT] && !fc_ff[afs_pkg::FC_FIVE])
   `AFS_ASSERT_IMP(a_length_load, clock, reset, fire && item.op == afs_pkg::OP_LOAD_LENGTH && item.data != 8'd0, result.length_active[item.channel])
   `AFS_ASSERT_NXT(a_idle_step, clock, reset, tick && fc_ff[afs_pkg::FC_FIVE] && step_ff == afs_pkg::FIVE_IDLE, env_ff == $past(env_ff) && step_ff == 3'd0)

endmodule

`default_nettype wire

// ===== src/apu_frame_sequencer_unit.sv =====
// Top level of the frame sequencer unit
`default_nettype none

// Sound-unit frame sequencer: each request item is a frame tick or a write to
// the channel registers, length counters, frame control or reload flags, and
// yields exactly one response item with the state after that item. An item
// goes through an input register, combinational update logic and a response
// register. A new item is taken every cycle while responses are being taken;
// when a result waits, the input register can still hold one more item.

module apu_frame_sequencer_unit (
   input wire logic clock,
   input wire logic reset,
   afs_req_if.sink  req_if,
   afs_rsp_if.source rsp_if
);

   afs_pkg::req_item_type req_item, hold_item;
   afs_pkg::rsp_item_type core_result, rsp_item_ff, rsp_item_in;
   logic                  hold_valid, advance, fire;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_item.op        = req_if.op;
   assign req_item.reg_index = req_if.reg_index;
   assign req_item.channel   = req_if.channel;
   assign req_item.data      = req_if.data;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign fire    = hold_valid && advance;

   afs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_item    (req_item),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   afs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (hold_item),
      .result (core_result)
   );

   always_comb begin
      rsp_valid_in = advance ? hold_valid : rsp_valid_ff;
      rsp_item_in  = fire ? core_result : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.frame_irq     = rsp_item_ff.frame_irq;
   assign rsp_if.length_active = rsp_item_ff.length_active;
   assign rsp_if.pulse0_volume = rsp_item_ff.pulse0_volume;
   assign rsp_if.pulse1_volume = rsp_item_ff.pulse1_volume;
   assign rsp_if.noise_volume  = rsp_item_ff.noise_volume;
   assign rsp_if.linear_active = rsp_item_ff.linear_active;
   assign rsp_if.pulse0_period = rsp_item_ff.pulse0_period;
   assign rsp_if.pulse1_period = rsp_item_ff.pulse1_period;
   assign rsp_if.sweep_mute    = rsp_item_ff.sweep_mute;

endmodule

`default_nettype wire
